/* design/lla_pkg.sv */
// Shared types and constants for the life-like automaton step block.
package lla_pkg;

   localparam int CMD_W       = 2;
   localparam int INDEX_W     = 6;
   localparam int SIZE_W      = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int COUNT_W     = 4;

   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_ROWS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_COLS = 2'd1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   localparam logic [COUNT_W-1:0] BIRTH_COUNT = 4'd3;
   localparam logic [COUNT_W-1:0] SURVIVE_MIN = 4'd1;
   localparam logic [COUNT_W-1:0] SURVIVE_MAX = 4'd4;

   // row write source
   localparam logic [1:0] WR_CLEAR = 2'd0;
   localparam logic [1:0] WR_CELL  = 2'd1;
   localparam logic [1:0] WR_GEN   = 2'd2;

   typedef struct packed {
      logic       latch;        // capture request word
      logic       rd_en;
      logic       rd_use_req;   // read address from request row
      logic       wr_en;
      logic       wr_use_req;   // write address from latched row
      logic [1:0] wr_src;
      logic       win_clear;
      logic       win_shift;
      logic       below_valid;
      logic       rsp_load;
   } lla_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             in_range;
      logic             out_free;
   } lla_stat_type;

endpackage

/* design/lla_ctrl.sv */
// Controller state machine: clearing pass, cell access and row-sweep sequencing.
module lla_ctrl #(
   parameter int MAX_ROWS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic [lla_pkg::CMD_W-1:0]           req_command,
   output logic                                req_stall,
   input  lla_pkg::lla_stat_type               stat,
   input  logic [$clog2(MAX_ROWS+2)-1:0]       eff_rows,
   output lla_pkg::lla_cmd_type                cmd,
   output logic [$clog2(MAX_ROWS)-1:0]         rd_addr,
   output logic [$clog2(MAX_ROWS)-1:0]         wr_addr
);

   localparam int AW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_ROWS+2);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_ACCESS = 2'd2;
   localparam logic [1:0] ST_ADV    = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] k_m2;
   logic          last;

   assign req_stall = (state_ff != ST_IDLE);
   assign k_m2      = CW'(k_ff - CW'(2));
   assign last      = (k_ff == CW'(eff_rows + CW'(1)));

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      cmd      = '0;
      rd_addr  = k_ff[AW-1:0];
      wr_addr  = k_ff[AW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = lla_pkg::WR_CLEAR;
            if (k_ff == CW'(MAX_ROWS - 1)) begin
               state_in = ST_IDLE;
               k_in     = '0;
            end else begin
               k_in = CW'(k_ff + CW'(1));
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               if (req_command == lla_pkg::CMD_ADVANCE) begin
                  cmd.win_clear = 1'b1;
                  k_in          = '0;
                  state_in      = ST_ADV;
               end else begin
                  cmd.rd_en      = 1'b1;
                  cmd.rd_use_req = 1'b1;
                  state_in       = ST_ACCESS;
               end
            end
         end
         ST_ACCESS: begin
            if (stat.out_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.wr_en      = (stat.command == lla_pkg::CMD_WRITE) && stat.in_range;
               cmd.wr_use_req = 1'b1;
               cmd.wr_src     = lla_pkg::WR_CELL;
               state_in       = ST_IDLE;
            end
         end
         ST_ADV: begin
            // k: read row k, window sees row k-1 below, writes new row k-2
            if (!last || stat.out_free) begin
               cmd.rd_en       = (k_ff < eff_rows);
               cmd.below_valid = (k_ff >= CW'(1)) && (k_ff <= eff_rows);
               cmd.win_shift   = (k_ff >= CW'(1));
               cmd.wr_en       = (k_ff >= CW'(2));
               cmd.wr_src      = lla_pkg::WR_GEN;
               wr_addr         = k_m2[AW-1:0];
               if (last) begin
                  cmd.rsp_load = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  k_in = CW'(k_ff + CW'(1));
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

endmodule

/* design/lla_datapath.sv */
// Datapath: grid memory, row window, neighbor count and rule, config and response registers.
module lla_datapath #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [lla_pkg::CMD_W-1:0]            req_command,
   input  logic [lla_pkg::INDEX_W-1:0]          req_row_index,
   input  logic [lla_pkg::INDEX_W-1:0]          req_col_index,
   input  logic                                 req_cell_in,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic                                 rsp_cell_out,
   input  logic                                 csr_valid,
   input  logic [lla_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lla_pkg::SIZE_W-1:0]           csr_wdata,
   input  lla_pkg::lla_cmd_type                 cmd,
   input  logic [$clog2(MAX_ROWS)-1:0]          rd_addr,
   input  logic [$clog2(MAX_ROWS)-1:0]          wr_addr,
   output lla_pkg::lla_stat_type                stat,
   output logic [$clog2(MAX_ROWS+2)-1:0]        eff_rows
);

   localparam int AW  = $clog2(MAX_ROWS);
   localparam int CW  = $clog2(MAX_ROWS+2);
   localparam int CCW = $clog2(MAX_COLS+1);
   localparam int CIW = $clog2(MAX_COLS);

   logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
   logic [MAX_COLS-1:0] rd_data_ff;

   logic [lla_pkg::SIZE_W-1:0]  rows_ff, cols_ff;
   logic [CCW-1:0]              eff_cols;
   logic [MAX_COLS-1:0]         col_mask;

   logic [lla_pkg::CMD_W-1:0]   cmd_ff;
   logic [lla_pkg::INDEX_W-1:0] row_ff, col_ff;
   logic                        cell_ff;
   logic                        inside_ff;
   logic                        in_range;

   logic [MAX_COLS-1:0]         up_ff, mid_ff;
   logic [MAX_COLS-1:0]         below;
   logic [MAX_COLS+1:0]         up_p, mid_p, below_p;
   logic [lla_pkg::COUNT_W-1:0] cnt [MAX_COLS];
   logic [MAX_COLS-1:0]         gen_row;
   logic [MAX_COLS-1:0]         cell_row;
   logic [MAX_COLS-1:0]         wr_data;
   logic [AW-1:0]               rd_addr_mux, wr_addr_mux;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_cell_ff;

   assign eff_rows = (32'(rows_ff) > MAX_ROWS) ? CW'(MAX_ROWS) : CW'(rows_ff);
   assign eff_cols = (32'(cols_ff) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_ff);

   always_comb begin
      for (int c = 0; c < MAX_COLS; c++) begin
         col_mask[c] = (32'(eff_cols) > c);
      end
   end

   assign in_range = (32'(req_row_index) < 32'(eff_rows)) &&
                     (32'(req_col_index) < 32'(eff_cols));

   assign below   = cmd.below_valid ? rd_data_ff : '0;
   assign up_p    = {1'b0, up_ff & col_mask, 1'b0};
   assign mid_p   = {1'b0, mid_ff & col_mask, 1'b0};
   assign below_p = {1'b0, below & col_mask, 1'b0};

   always_comb begin
      for (int c = 0; c < MAX_COLS; c++) begin
         cnt[c] = lla_pkg::COUNT_W'(up_p[c]) + lla_pkg::COUNT_W'(up_p[c+1]) +
                  lla_pkg::COUNT_W'(up_p[c+2]) + lla_pkg::COUNT_W'(mid_p[c]) +
                  lla_pkg::COUNT_W'(mid_p[c+2]) + lla_pkg::COUNT_W'(below_p[c]) +
                  lla_pkg::COUNT_W'(below_p[c+1]) + lla_pkg::COUNT_W'(below_p[c+2]);
         if (!col_mask[c]) begin
            gen_row[c] = mid_ff[c];
         end else if (mid_ff[c]) begin
            gen_row[c] = cnt[c] inside {[lla_pkg::SURVIVE_MIN:lla_pkg::SURVIVE_MAX]};
         end else begin
            gen_row[c] = (cnt[c] == lla_pkg::BIRTH_COUNT);
         end
      end
   end

   always_comb begin
      cell_row                = rd_data_ff;
      cell_row[CIW'(col_ff)]  = cell_ff;
   end

   always_comb begin
      case (cmd.wr_src)
         lla_pkg::WR_CELL: wr_data = cell_row;
         lla_pkg::WR_GEN:  wr_data = gen_row;
         default:          wr_data = '0;
      endcase
   end

   assign rd_addr_mux = cmd.rd_use_req ? AW'(req_row_index) : rd_addr;
   assign wr_addr_mux = cmd.wr_use_req ? AW'(row_ff) : wr_addr;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         grid_mem[wr_addr_mux] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= grid_mem[rd_addr_mux];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff    <= req_command;
         row_ff    <= req_row_index;
         col_ff    <= req_col_index;
         cell_ff   <= req_cell_in;
         inside_ff <= in_range;
      end
      if (cmd.win_clear) begin
         up_ff  <= '0;
         mid_ff <= '0;
      end else if (cmd.win_shift) begin
         up_ff  <= mid_ff;
         mid_ff <= below;
      end
      if (cmd.rsp_load) begin
         rsp_cell_ff <= (cmd_ff == lla_pkg::CMD_READ) && inside_ff &&
                        rd_data_ff[CIW'(col_ff)];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rows_ff      <= lla_pkg::SIZE_RESET;
         cols_ff      <= lla_pkg::SIZE_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && (csr_index == lla_pkg::CSR_ACTIVE_ROWS)) begin
            rows_ff <= csr_wdata;
         end
         if (csr_valid && (csr_index == lla_pkg::CSR_ACTIVE_COLS)) begin
            cols_ff <= csr_wdata;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cell_out = rsp_cell_ff;

   assign stat.command  = cmd_ff;
   assign stat.in_range = inside_ff;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

/* design/life_like_automaton_step.sv */
// Top level of the life-like (B3/S1234) cellular automaton step block.
// Request words carry a command (write cell, read cell, advance one generation),
// a row and column index and a cell value; every request gives one response word
// with cell_out, the cell read for an in-range read command and 0 otherwise.
// Write and read each first fetch the MAX_COLS-bit row from the grid memory, then
// merge or select the bit and load the response register once that register is free.
// In an advance the grid memory is swept one row per cycle, the final write-back
// waiting for a free response register, through a three-row window, new rows written
// back two rows behind the read pointer over its single read and single write port.
// The response register frees the request side: a new word is taken while a
// response waits, and the block holds its last step only while that response is held by rsp_stall.
// After reset a clearing pass writes MAX_ROWS rows of dead cells with req_stall
// high; active_rows and active_cols return to 64.
// Configuration writes (csr_ready is always high) must go in only while no request
// is in flight; the block itself does not enforce this.
module life_like_automaton_step #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [lla_pkg::CMD_W-1:0]          req_command,
   input  logic [lla_pkg::INDEX_W-1:0]        req_row_index,
   input  logic [lla_pkg::INDEX_W-1:0]        req_col_index,
   input  logic                               req_cell_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_cell_out,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lla_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lla_pkg::SIZE_W-1:0]         csr_wdata
);

   lla_pkg::lla_cmd_type                cmd;
   lla_pkg::lla_stat_type               stat;
   logic [$clog2(MAX_ROWS+2)-1:0]       eff_rows;
   logic [$clog2(MAX_ROWS)-1:0]         rd_addr, wr_addr;

   assign csr_ready = 1'b1;

   lla_ctrl #(
      .MAX_ROWS (MAX_ROWS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .stat        (stat),
      .eff_rows    (eff_rows),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .wr_addr     (wr_addr)
   );

   lla_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_command   (req_command),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_cell_in   (req_cell_in),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_cell_out  (rsp_cell_out),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .rd_addr       (rd_addr),
      .wr_addr       (wr_addr),
      .stat          (stat),
      .eff_rows      (eff_rows)
   );

endmodule

/* test/tb_life_like_automaton_step.sv */
// Testbench for the B3/S1234 cellular automaton step block: scoreboarded random and directed words.
`timescale 1ns / 1ps

module tb_life_like_automaton_step;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 8;
   localparam int WORD_TARGET    = 430;

   localparam logic [lla_pkg::CMD_W-1:0]       CMD_NONE    = 2'd3;
   localparam logic [lla_pkg::CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [lla_pkg::CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   class grid_scoreboard;
      bit [63:0]                grid [64];
      bit [lla_pkg::SIZE_W-1:0] rows_reg;
      bit [lla_pkg::SIZE_W-1:0] cols_reg;
      bit                       cell_out_q [$];
      int                       errors;

      function new();
         foreach (grid[r]) grid[r] = '0;
         rows_reg = lla_pkg::SIZE_RESET;
         cols_reg = lla_pkg::SIZE_RESET;
         errors   = 0;
      endfunction

      function int span(bit [lla_pkg::SIZE_W-1:0] v);
         return (v > 64) ? 64 : int'(v);
      endfunction

      function void set_reg(logic [lla_pkg::CSR_INDEX_W-1:0] idx,
                            logic [lla_pkg::SIZE_W-1:0] data);
         if (idx == lla_pkg::CSR_ACTIVE_ROWS) rows_reg = data;
         else if (idx == lla_pkg::CSR_ACTIVE_COLS) cols_reg = data;
      endfunction

      function int pending();
         return cell_out_q.size();
      endfunction

      function void step_generation();
         bit [63:0] next_grid [64];
         int nr, nc, cnt, rr, cc;
         nr = span(rows_reg);
         nc = span(cols_reg);
         next_grid = grid;
         for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
               cnt = 0;
               for (int dr = -1; dr <= 1; dr++) begin
                  for (int dc = -1; dc <= 1; dc++) begin
                     rr = r + dr;
                     cc = c + dc;
                     if ((dr != 0 || dc != 0) && rr >= 0 && rr < nr && cc >= 0 && cc < nc)
                        cnt += grid[rr][cc];
                  end
               end
               if (grid[r][c])
                  next_grid[r][c] = (cnt >= lla_pkg::SURVIVE_MIN) &&
                                    (cnt <= lla_pkg::SURVIVE_MAX);
               else
                  next_grid[r][c] = (cnt == lla_pkg::BIRTH_COUNT);
            end
         end
         grid = next_grid;
      endfunction

      function void note(logic [lla_pkg::CMD_W-1:0] cmd, logic [lla_pkg::INDEX_W-1:0] row,
                         logic [lla_pkg::INDEX_W-1:0] col, logic cell_bit);
         bit in_range;
         bit out_bit;
         out_bit  = 1'b0;
         in_range = (row < span(rows_reg)) && (col < span(cols_reg));
         case (cmd)
            lla_pkg::CMD_WRITE: begin
               if (in_range) grid[row][col] = cell_bit;
            end
            lla_pkg::CMD_READ: begin
               if (in_range) out_bit = grid[row][col];
            end
            lla_pkg::CMD_ADVANCE: begin
               step_generation();
            end
            default: ;
         endcase
         cell_out_q.push_back(out_bit);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check(logic got);
         bit want;
         if (cell_out_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word, cell_out=%b", got));
         end else begin
            want = cell_out_q.pop_front();
            if (got !== want)
               report_mismatch($sformatf("cell_out got %b want %b", got, want));
         end
      endtask

      task finish_check();
         if (cell_out_q.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", cell_out_q.size()));
      endtask
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [lla_pkg::CMD_W-1:0]       req_command;
   logic [lla_pkg::INDEX_W-1:0]     req_row_index;
   logic [lla_pkg::INDEX_W-1:0]     req_col_index;
   logic                            req_cell_in;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic                            rsp_cell_out;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [lla_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [lla_pkg::SIZE_W-1:0]      csr_wdata;

   grid_scoreboard board = new();
   bit quiet;
   int words_sent;
   int idle_cycles;

   life_like_automaton_step u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_cell_in   (req_cell_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cell_out  (rsp_cell_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 32);
   end

   // outputs and handshakes are sampled mid-cycle, acted on at the next edge
   always begin
      bit taken;
      bit got;
      @(negedge clock);
      taken = rsp_valid && !rsp_stall;
      got   = rsp_cell_out;
      @(posedge clock);
      if (taken) board.check(got);
   end

   always begin
      bit active;
      @(negedge clock);
      active = (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
               (csr_valid && csr_ready);
      @(posedge clock);
      if (active) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   function logic [lla_pkg::INDEX_W-1:0] rand_index();
      return lla_pkg::INDEX_W'($urandom_range(63));
   endfunction

   function logic rand_bit();
      return 1'($urandom_range(1));
   endfunction

   task send_word(logic [lla_pkg::CMD_W-1:0] cmd, logic [lla_pkg::INDEX_W-1:0] row,
                  logic [lla_pkg::INDEX_W-1:0] col, logic cell_bit);
      int gap;
      bit taken;
      gap = 0;
      while (!quiet && $urandom_range(99) < 32) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_row_index <= row;
      req_col_index <= col;
      req_cell_in   <= cell_bit;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      board.note(cmd, row, col, cell_bit);
      words_sent++;
   endtask

   task drain();
      req_valid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (HOLD_CYCLES) @(posedge clock);
   endtask

   task write_reg(logic [lla_pkg::CSR_INDEX_W-1:0] idx, logic [lla_pkg::SIZE_W-1:0] data);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      board.set_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task set_size(logic [lla_pkg::SIZE_W-1:0] rows, logic [lla_pkg::SIZE_W-1:0] cols);
      write_reg(lla_pkg::CSR_ACTIVE_ROWS, rows);
      write_reg(lla_pkg::CSR_ACTIVE_COLS, cols);
   endtask

   function logic [lla_pkg::SIZE_W-1:0] pick_size();
      int p;
      p = $urandom_range(99);
      if (p < 4) return '0;
      if (p < 12) return lla_pkg::SIZE_W'($urandom_range(2, 1));
      if (p < 70) return lla_pkg::SIZE_W'($urandom_range(12, 3));
      if (p < 84) return lla_pkg::SIZE_RESET;
      if (p < 92) return lla_pkg::SIZE_W'($urandom_range(127, 65));
      return lla_pkg::SIZE_W'($urandom_range(63, 13));
   endfunction

   // mostly inside the active area, sometimes anywhere
   function logic [lla_pkg::INDEX_W-1:0] pick_index(int lim);
      if (lim == 0 || $urandom_range(99) < 15) return rand_index();
      return lla_pkg::INDEX_W'($urandom_range(lim - 1));
   endfunction

   task random_phase();
      int nr, nc, p;
      nr = board.span(board.rows_reg);
      nc = board.span(board.cols_reg);
      repeat ($urandom_range(20, 4))
         send_word(lla_pkg::CMD_WRITE, pick_index(nr), pick_index(nc),
                   $urandom_range(99) < 60);
      repeat ($urandom_range(40, 15)) begin
         p = $urandom_range(99);
         if (p < 15)
            send_word(lla_pkg::CMD_ADVANCE, rand_index(), rand_index(), rand_bit());
         else if (p < 55)
            send_word(lla_pkg::CMD_READ, pick_index(nr), pick_index(nc), rand_bit());
         else if (p < 85)
            send_word(lla_pkg::CMD_WRITE, pick_index(nr), pick_index(nc), rand_bit());
         else if (p < 90)
            send_word(CMD_NONE, rand_index(), rand_index(), rand_bit());
         else
            send_word(lla_pkg::CMD_W'($urandom_range(3)), rand_index(), rand_index(),
                      rand_bit());
      end
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_command   = lla_pkg::CMD_WRITE;
      req_row_index = '0;
      req_col_index = '0;
      req_cell_in   = 1'b0;
      rsp_stall     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = lla_pkg::CSR_ACTIVE_ROWS;
      csr_wdata     = lla_pkg::SIZE_RESET;
      quiet         = 1'b0;
      words_sent    = 0;
      idle_cycles   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // corners, a row of three live cells, dead write and the unused command on the full grid
      send_word(lla_pkg::CMD_READ, 6'd0, 6'd0, 1'b1);
      send_word(lla_pkg::CMD_READ, 6'd63, 6'd63, 1'b0);
      send_word(lla_pkg::CMD_WRITE, 6'd0, 6'd0, 1'b1);
      send_word(lla_pkg::CMD_WRITE, 6'd63, 6'd63, 1'b1);
      send_word(lla_pkg::CMD_WRITE, 6'd0, 6'd63, 1'b1);
      send_word(lla_pkg::CMD_WRITE, 6'd63, 6'd0, 1'b0);
      send_word(lla_pkg::CMD_READ, 6'd0, 6'd0, 1'b0);
      send_word(lla_pkg::CMD_READ, 6'd63, 6'd63, 1'b0);
      send_word(lla_pkg::CMD_WRITE, 6'd10, 6'd9, 1'b1);
      send_word(lla_pkg::CMD_WRITE, 6'd10, 6'd10, 1'b1);
      send_word(lla_pkg::CMD_WRITE, 6'd10, 6'd11, 1'b1);
      send_word(lla_pkg::CMD_ADVANCE, 6'd63, 6'd0, 1'b1);
      send_word(lla_pkg::CMD_READ, 6'd9, 6'd10, 1'b0);
      send_word(lla_pkg::CMD_READ, 6'd10, 6'd9, 1'b0);
      send_word(CMD_NONE, 6'd21, 6'd42, 1'b1);
      send_word(lla_pkg::CMD_ADVANCE, 6'd0, 6'd63, 1'b0);
      send_word(lla_pkg::CMD_READ, 6'd0, 6'd0, 1'b1);
      drain();

      // no active rows
      set_size(7'd0, lla_pkg::SIZE_RESET);
      send_word(lla_pkg::CMD_WRITE, 6'd5, 6'd5, 1'b1);
      send_word(lla_pkg::CMD_READ, 6'd10, 6'd10, 1'b0);
      send_word(lla_pkg::CMD_ADVANCE, 6'd0, 6'd0, 1'b0);
      drain();

      // saturating size, hidden cells visible again
      set_size(7'd127, 7'd127);
      send_word(lla_pkg::CMD_READ, 6'd10, 6'd10, 1'b0);
      drain();

      set_size(7'd3, 7'd3);
      write_reg(CSR_SPARE_B, 7'h7F);
      write_reg(CSR_SPARE_A, 7'h00);
      send_word(lla_pkg::CMD_WRITE, 6'd1, 6'd1, 1'b1);
      send_word(lla_pkg::CMD_WRITE, 6'd5, 6'd1, 1'b1);
      send_word(lla_pkg::CMD_ADVANCE, 6'd0, 6'd0, 1'b0);
      send_word(lla_pkg::CMD_READ, 6'd1, 6'd1, 1'b0);
      drain();

      while (words_sent < WORD_TARGET) begin
         quiet = (words_sent >= 200) && (words_sent < 300);
         if ($urandom_range(99) < 5)
            write_reg($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B,
                      lla_pkg::SIZE_W'($urandom_range(127)));
         set_size(pick_size(), pick_size());
         random_phase();
         drain();
      end
      quiet = 1'b0;

      board.finish_check();
      if (board.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
